// ===== hdl/cfbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbp_pkg
// Shared constants and types for the centered FIR border padding unit.
// ----------------------------------------------------------------------------
package cfbp_pkg;

	localparam int MAX_TAPS    = 32;
	localparam int TAP_AW      = $clog2(MAX_TAPS);
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 20;
	localparam int CNT_W       = 6;
	localparam int OFS_W       = 8;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int OUT_BITS    = 37;

	localparam logic OP_TAP    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [0:0] REG_PAD_MODE  = 1'b0;
	localparam logic [0:0] REG_TAP_COUNT = 1'b1;

	localparam logic PAD_ZERO = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MAC  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/cfbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cfbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire  logic                     clk,
	input  wire  logic                     we,
	input  wire  logic [$clog2(DEPTH)-1:0] waddr,
	input  wire  logic [WIDTH-1:0]         wdata,
	input  wire  logic [$clog2(DEPTH)-1:0] raddr,
	output logic       [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/centered_fir_border_padding_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// centered_fir_border_padding_unit
// Centered 1-D correlation with zero or edge-replicate padding. One shared
// 16x16 multiply-accumulate walks the taps, weights and samples sit in RAMs.
// ----------------------------------------------------------------------------
// A tap write, or a sample that yields no result, leaves the unit idle and ready.
// A sample with a result is walked through one MAC per tap in use (T taps), and
// no new beat is accepted until its result is loaded into the output register.
// A final sample yields up to T - T/2 results, one MAC pass for each.
// Reset clears control and the tap valid bits (unwritten taps read as zero) and
// sets zero padding and a tap count of one; no clearing pass.
module centered_fir_border_padding_unit
	import cfbp_pkg::*;
(
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          cfg_write,
	input  wire  logic [0:0]                    cfg_index,
	input  wire  logic [CNT_W-1:0]              cfg_data,
	input  wire  logic                          in_valid,
	output logic                                in_ready,
	input  wire  logic                          opcode,
	input  wire  logic [TAP_AW-1:0]             tap_index,
	input  wire  logic signed [SAMPLE_BITS-1:0] data_value,
	input  wire  logic                          sequence_end,
	output logic                                out_valid,
	input  wire  logic                          out_ready,
	output logic signed [OUT_BITS-1:0]          filtered_value,
	output logic                                end_of_output
);

	state_t state_q;

	logic                    pad_mode_q;
	logic [CNT_W-1:0]        tap_count_q;
	logic [MAX_TAPS-1:0]     wvalid_q;
	logic [TAP_AW-1:0]       wp_q;
	logic [SAMPLE_BITS-1:0]  first_sample_q;
	logic [SAMPLE_BITS-1:0]  newest_q;
	logic [COUNT_BITS-1:0]   samples_seen_q;
	logic [COUNT_BITS-1:0]   n_q;
	logic                    last_q;
	logic signed [OFS_W-1:0] r_q;
	logic [TAP_AW-1:0]       k_q;
	logic signed [OUT_BITS-1:0] acc_q;
	logic                    done_q;

	logic [CNT_W-1:0]        t_eff;
	logic [CNT_W-1:0]        half;
	logic [CNT_W-1:0]        look;
	logic [CNT_W-1:0]        mlen;
	logic [TAP_AW-1:0]       k_last;
	logic                    in_fire;
	logic                    tap_we;
	logic                    samp_we;
	logic [TAP_AW-1:0]       samp_waddr;

	logic signed [OFS_W-1:0] e;
	logic [OFS_W-1:0]        negd;
	logic                    above;
	logic                    below;
	logic [TAP_AW-1:0]       samp_raddr;
	logic [SAMPLE_BITS-1:0]  samp_rdata;
	logic [SAMPLE_BITS-1:0]  wgt_rdata;
	logic                    issue;
	logic                    load_out;

	logic                    v_s1, skip_s1, ram_s1, wv_s1, last_s1;
	logic [SAMPLE_BITS-1:0]  xc_s1;
	logic                    v_s2, last_s2;
	logic signed [PROD_BITS-1:0]   prod_s2;
	logic signed [SAMPLE_BITS-1:0] x_sel;
	logic signed [SAMPLE_BITS-1:0] w_sel;

	always_comb begin
		if (tap_count_q == '0) begin
			t_eff = CNT_W'(1);
		end else if (tap_count_q > CNT_W'(MAX_TAPS)) begin
			t_eff = CNT_W'(MAX_TAPS);
		end else begin
			t_eff = tap_count_q;
		end
		half   = t_eff >> 1;
		look   = t_eff - CNT_W'(1) - half;
		mlen   = (samples_seen_q < COUNT_BITS'(look)) ? samples_seen_q[CNT_W-1:0] : look;
		k_last = TAP_AW'(t_eff - CNT_W'(1));
	end

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign tap_we     = in_fire && (opcode == OP_TAP);
	assign samp_we    = in_fire && (opcode == OP_SAMPLE);
	assign samp_waddr = wp_q + TAP_AW'(1);

	// offset of the needed sample relative to the newest one
	always_comb begin
		e          = r_q + $signed({{(OFS_W-TAP_AW){1'b0}}, k_q})
			- $signed({{(OFS_W-CNT_W){1'b0}}, half});
		negd       = OFS_W'(-e);
		above      = !e[OFS_W-1] && (e != '0);
		below      = e[OFS_W-1] && (n_q < COUNT_BITS'(negd));
		samp_raddr = wp_q - negd[TAP_AW-1:0];
	end

	assign issue    = (state_q == S_MAC);
	assign load_out = (state_q == S_FIN) && done_q && (!out_valid || out_ready);

	cfbp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_wgt_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (tap_index),
		.wdata (data_value),
		.raddr (k_q),
		.rdata (wgt_rdata)
	);

	cfbp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_samp_ram (
		.clk   (clk),
		.we    (samp_we),
		.waddr (samp_waddr),
		.wdata (data_value),
		.raddr (samp_raddr),
		.rdata (samp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_mode_q  <= PAD_ZERO;
			tap_count_q <= CNT_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PAD_MODE:  pad_mode_q  <= cfg_data[0];
				REG_TAP_COUNT: tap_count_q <= cfg_data;
				default:       pad_mode_q  <= pad_mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (tap_we) begin
			wvalid_q[tap_index] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			wp_q           <= '0;
			samples_seen_q <= '0;
			first_sample_q <= '0;
			newest_q       <= '0;
			n_q            <= '0;
			last_q         <= 1'b0;
			r_q            <= '0;
			k_q            <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (samp_we) begin
						wp_q     <= samp_waddr;
						newest_q <= data_value;
						n_q      <= samples_seen_q;
						last_q   <= sequence_end;
						k_q      <= '0;
						if (samples_seen_q == '0) begin
							first_sample_q <= data_value;
						end
						if (sequence_end) begin
							samples_seen_q <= '0;
							r_q            <= -$signed({{(OFS_W-CNT_W){1'b0}}, mlen});
							state_q        <= S_MAC;
						end else begin
							if (!(&samples_seen_q)) begin
								samples_seen_q <= samples_seen_q + COUNT_BITS'(1);
							end
							if (samples_seen_q >= COUNT_BITS'(look)) begin
								r_q     <= -$signed({{(OFS_W-CNT_W){1'b0}}, look});
								state_q <= S_MAC;
							end
						end
					end
				end
				S_MAC: begin
					k_q <= k_q + TAP_AW'(1);
					if (k_q == k_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						k_q <= '0;
						if (!last_q || r_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							r_q     <= r_q + OFS_W'(1);
							state_q <= S_MAC;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// MAC pipeline: s1 = RAM read, s2 = product, then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && (k_q == k_last);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		skip_s1 <= (above || below) && (pad_mode_q == PAD_ZERO);
		ram_s1  <= !above && !below;
		xc_s1   <= above ? newest_q : first_sample_q;
		wv_s1   <= wvalid_q[k_q];
	end

	always_comb begin
		x_sel = ram_s1 ? samp_rdata : xc_s1;
		w_sel = wv_s1 ? wgt_rdata : '0;
	end

	always_ff @(posedge clk) begin
		if (skip_s1) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= x_sel * w_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			done_q <= 1'b0;
		end else if (load_out) begin
			acc_q  <= '0;
			done_q <= 1'b0;
		end else if (v_s2) begin
			acc_q <= acc_q + OUT_BITS'(prod_s2);
			if (last_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filtered_value <= acc_q;
			end_of_output  <= last_q && (r_q == '0);
		end
	end

endmodule
`default_nettype wire

// ===== tb/centered_fir_border_padding_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_fir_border_padding_unit_tb
// Self-checking bench for the centered correlation unit. A directed table of
// tap writes, samples and register writes is followed by random sequences
// with random tap sets, tap counts and pad modes. A behavioral model of the
// correlation predicts each beat the table does not spell out; all beats are
// checked in order. Both channels idle in random bursts, the output side holds
// off long enough to back the unit up, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module centered_fir_border_padding_unit_tb;
	import cfbp_pkg::*;

	localparam int RANDOM_BEATS   = 200;
	localparam int CALM_BEATS     = 40;
	localparam int SETTLE_CYCLES  = 48;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] value;
		logic                       final_out;
	} result_t;

	typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

	typedef struct packed {
		row_kind_t                     kind;
		logic                          op;
		logic [TAP_AW-1:0]             sel;
		logic signed [SAMPLE_BITS-1:0] data;
		logic                          is_last;
		logic                          typed;
		logic signed [OUT_BITS-1:0]    want;
	} row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_write = 1'b0;
	logic [0:0]                    cfg_index = REG_PAD_MODE;
	logic [CNT_W-1:0]              cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          opcode = OP_TAP;
	logic [TAP_AW-1:0]             tap_index = '0;
	logic signed [SAMPLE_BITS-1:0] data_value = '0;
	logic                          sequence_end = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b1;
	logic signed [OUT_BITS-1:0]    filtered_value;
	logic                          end_of_output;

	// model of the unit
	logic                          pad_q;
	logic [CNT_W-1:0]              taps_q;
	logic signed [SAMPLE_BITS-1:0] coef [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] head_q;
	logic [COUNT_BITS-1:0]         seen_q;

	result_t pending_outputs [$];
	int      beats_sent = 0;
	int      outputs_seen = 0;
	int      mismatches = 0;
	bit      calm = 1'b0;
	bit      sender_gaps = 1'b1;
	bit      hold_armed = 1'b0;
	int      hold_mark = 0;

	centered_fir_border_padding_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.tap_index      (tap_index),
		.data_value     (data_value),
		.sequence_end   (sequence_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_value (filtered_value),
		.end_of_output  (end_of_output)
	);

	always #5 clk = ~clk;

	function automatic int active_taps();
		if (taps_q == 0) begin
			return 1;
		end
		if (taps_q > MAX_TAPS) begin
			return MAX_TAPS;
		end
		return int'(taps_q);
	endfunction

	// output i while the newest sample has index n
	function automatic logic signed [OUT_BITS-1:0] correlate(input int i, input int n,
			input int t);
		longint acc;
		longint x;
		int     j;
		int     k;
		bit     hit;
		acc = 0;
		for (k = 0; k < t; k++) begin
			j = i - t / 2 + k;
			hit = 1'b1;
			x = 0;
			if (j > n) begin
				hit = (pad_q != PAD_ZERO);
				x = longint'(hist[0]);
			end else if (j < 0) begin
				hit = (pad_q != PAD_ZERO);
				x = longint'(head_q);
			end else if (n - j >= MAX_TAPS) begin
				hit = 1'b0;
			end else begin
				x = longint'(hist[n - j]);
			end
			if (hit) begin
				acc += x * longint'(coef[k]);
			end
		end
		return acc[OUT_BITS-1:0];
	endfunction

	task automatic reset_model();
		int k;
		pad_q = PAD_ZERO;
		taps_q = 1;
		head_q = '0;
		seen_q = '0;
		for (k = 0; k < MAX_TAPS; k++) begin
			coef[k] = '0;
			hist[k] = '0;
		end
	endtask

	task automatic model_beat(input logic op, input logic [TAP_AW-1:0] tap,
			input logic signed [SAMPLE_BITS-1:0] value, input logic is_last);
		int      d;
		int      n;
		int      t;
		int      from;
		int      i;
		result_t r;
		if (op == OP_TAP) begin
			coef[tap] = value;
		end else begin
			for (d = MAX_TAPS - 1; d > 0; d--) begin
				hist[d] = hist[d - 1];
			end
			hist[0] = value;
			n = int'(seen_q);
			if (n == 0) begin
				head_q = value;
			end
			if (seen_q != '1) begin
				seen_q++;
			end
			t = active_taps();
			from = n - (t - 1 - t / 2);
			if (!is_last) begin
				if (from >= 0) begin
					r.value = correlate(from, n, t);
					r.final_out = 1'b0;
					pending_outputs = {pending_outputs, r};
				end
			end else begin
				if (from < 0) begin
					from = 0;
				end
				for (i = from; i <= n; i++) begin
					r.value = correlate(i, n, t);
					r.final_out = (i == n);
					pending_outputs = {pending_outputs, r};
				end
				seen_q = '0;
			end
		end
	endtask

	task automatic send_beat(input logic op, input logic [TAP_AW-1:0] tap,
			input logic signed [SAMPLE_BITS-1:0] value, input logic is_last,
			input logic typed, input logic signed [OUT_BITS-1:0] want);
		int      base;
		result_t r;
		if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		tap_index <= tap;
		data_value <= value;
		sequence_end <= is_last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		base = pending_outputs.size();
		model_beat(op, tap, value, is_last);
		if (typed) begin
			while (pending_outputs.size() > base) void'(pending_outputs.pop_back());
			r.value = want;
			r.final_out = 1'b1;
			pending_outputs = {pending_outputs, r};
		end
		beats_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [CNT_W-1:0] val);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_PAD_MODE) begin
			pad_q = val[0];
		end else begin
			taps_q = val;
		end
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_taps();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CNT_W'(MAX_TAPS);
			2: return CNT_W'($urandom_range(MAX_TAPS + 1, 63));
			3: return CNT_W'($urandom_range(9, MAX_TAPS - 1));
			default: return CNT_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic row_t reg_row(input logic [0:0] idx, input logic [CNT_W-1:0] val);
		row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.sel = TAP_AW'(idx);
		r.data = SAMPLE_BITS'(val);
		return r;
	endfunction

	function automatic row_t beat_row(input logic op, input logic [TAP_AW-1:0] tap,
			input logic signed [SAMPLE_BITS-1:0] value, input logic is_last);
		row_t r;
		r = '0;
		r.kind = ROW_BEAT;
		r.op = op;
		r.sel = tap;
		r.data = value;
		r.is_last = is_last;
		return r;
	endfunction

	// final sample of a one-output sequence with its result spelled out
	function automatic row_t checked_row(input logic signed [SAMPLE_BITS-1:0] value,
			input logic signed [OUT_BITS-1:0] want);
		row_t r;
		r = beat_row(OP_SAMPLE, '0, value, 1'b1);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: output %0d %s expected %0d got %0d",
				$time, outputs_seen, what, exp_v, got_v);
		end
	endtask

	initial begin : result_sink
		result_t want;
		int      stall_left;
		int      rate;
		stall_left = 0;
		rate = 1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				outputs_seen++;
				if (pending_outputs.size() == 0) begin
					note_mismatch("unexpected beat, value", 0, longint'(filtered_value));
				end else begin
					want = pending_outputs.pop_front();
					if (filtered_value !== want.value) begin
						note_mismatch("filtered_value", longint'($signed(want.value)),
							longint'(filtered_value));
					end
					if (end_of_output !== want.final_out) begin
						note_mismatch("end_of_output", longint'(want.final_out),
							longint'(end_of_output));
					end
				end
			end
			if (hold_armed && outputs_seen >= hold_mark) begin
				hold_armed = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) < rate) begin
				stall_left = $urandom_range(1, 10);
			end
			if ($urandom_range(0, 63) == 0) begin
				rate = $urandom_range(0, 3);
			end
			out_ready <= (stall_left == 0);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		row_t plan [$];
		int   directed;
		int   phase;
		int   len;
		int   s;
		int   k;
		bit   ends;
		reset_model();

		plan = {plan, checked_row(16'sd0, 37'sd0)};
		plan = {plan, beat_row(OP_TAP, 5'd0, 16'sd16384, 1'b0)};
		plan = {plan, checked_row(16'sh7FFF, 37'sd536854528)};
		plan = {plan, checked_row(16'sh8000, -37'sd536870912)};
		plan = {plan, beat_row(OP_TAP, 5'd0, 16'sh8000, 1'b1)};
		plan = {plan, checked_row(16'sh8000, 37'sd1073741824)};
		plan = {plan, beat_row(OP_TAP, 5'd31, 16'sh7FFF, 1'b0)};
		plan = {plan, reg_row(REG_TAP_COUNT, 6'd3)};
		plan = {plan, beat_row(OP_TAP, 5'd0, 16'sd16384, 1'b0)};
		plan = {plan, beat_row(OP_TAP, 5'd1, 16'sh8000, 1'b0)};
		plan = {plan, beat_row(OP_TAP, 5'd2, 16'sh7FFF, 1'b0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd31, 16'sd100, 1'b0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, -16'sd5, 1'b0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sd7, 1'b1)};
		plan = {plan, reg_row(REG_PAD_MODE, 6'd1)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sh7FFF, 1'b0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sh8000, 1'b0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sd1, 1'b1)};
		plan = {plan, reg_row(REG_TAP_COUNT, 6'd0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sd5, 1'b1)};
		plan = {plan, reg_row(REG_TAP_COUNT, 6'd63)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sh8000, 1'b0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sh7FFF, 1'b1)};
		plan = {plan, reg_row(REG_TAP_COUNT, 6'd2)};
		plan = {plan, reg_row(REG_PAD_MODE, 6'd0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sd11, 1'b1)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, 16'sd9, 1'b0)};
		plan = {plan, beat_row(OP_SAMPLE, 5'd0, -16'sd9, 1'b1)};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_REG) begin
				write_reg(plan[r].sel[0], plan[r].data[CNT_W-1:0]);
			end else begin
				send_beat(plan[r].op, plan[r].sel, plan[r].data, plan[r].is_last,
					plan[r].typed, plan[r].want);
			end
		end
		directed = beats_sent;

		phase = 0;
		while (beats_sent < directed + RANDOM_BEATS) begin
			sender_gaps = ($urandom_range(0, 2) != 0);
			if (phase == 0) begin
				// long sequence against a stalled output side
				write_reg(REG_TAP_COUNT, 6'd5);
				write_reg(REG_PAD_MODE, CNT_W'($urandom_range(0, 1)));
				hold_armed = 1'b1;
				hold_mark = outputs_seen + 3;
				for (s = 0; s < 40; s++) begin
					send_beat(OP_SAMPLE, TAP_AW'($urandom), pick_word(), s == 39, 1'b0, '0);
				end
			end else if (phase == 1) begin
				// full-width taps and samples: largest sums
				write_reg(REG_TAP_COUNT, CNT_W'(MAX_TAPS));
				write_reg(REG_PAD_MODE, 6'd1);
				for (k = 0; k < MAX_TAPS; k++) begin
					send_beat(OP_TAP, TAP_AW'(k), 16'sh8000, 1'b0, 1'b0, '0);
				end
				for (s = 0; s < 4; s++) begin
					send_beat(OP_SAMPLE, '0, 16'sh8000, s == 3, 1'b0, '0);
				end
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					write_reg(REG_PAD_MODE, CNT_W'($urandom_range(0, 1)));
				end
				if ($urandom_range(0, 2) == 0) begin
					write_reg(REG_TAP_COUNT, pick_taps());
				end
				repeat ($urandom_range(0, 3)) begin
					send_beat(OP_TAP, TAP_AW'($urandom), pick_word(), 1'($urandom), 1'b0, '0);
				end
				len = $urandom_range(1, 12);
				ends = ($urandom_range(0, 5) != 0);
				for (s = 0; s < len; s++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_beat(OP_TAP, TAP_AW'($urandom), pick_word(), 1'($urandom),
							1'b0, '0);
					end
					send_beat(OP_SAMPLE, TAP_AW'($urandom), pick_word(),
						ends && (s == len - 1), 1'b0, '0);
				end
			end
			phase++;
			calm = (beats_sent >= directed + RANDOM_BEATS - CALM_BEATS);
		end

		settle();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/cfbp_pkg.sv
hdl/cfbp_ram.sv
hdl/centered_fir_border_padding_unit.sv
tb/centered_fir_border_padding_unit_tb.sv
